@@ hdl/slist_pkg.sv @@
// Shared types and constants for the sorted list engine.
// No dependencies; imported by every module of the block.
package slist_pkg;

    // Fixed field widths of the transaction ports
    localparam int KEY_W     = 32;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_POS = 2'd1,
        CMD_DEL_VAL = 2'd2,
        CMD_LIST    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_FETCH,
        S_MATCH,
        S_SHIFT,
        S_LIST,
        S_RESULT
    } t_state;

    // One result offered by the sequencer to the output register
    typedef struct packed {
        logic                    vld;
        t_status                 status;
        logic signed [KEY_W-1:0] value;
        logic [CNT_OUT_W-1:0]    count;
        logic                    last;
    } t_emit;

endpackage

@@ hdl/slist_mem.sv @@
// Key storage: one write port, one read port with registered read data.
// Depends on slist_pkg for the key width.
module slist_mem #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [slist_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [slist_pkg::KEY_W-1:0] o_rdata
);
    import slist_pkg::*;

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/slist_ctrl.sv @@
// Sequencer for the sorted list: walks the key memory one entry per cycle
// (a listing holds while its result is not granted) through a single comparator. Depends on slist_pkg.
module slist_ctrl #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command transaction
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic signed [slist_pkg::KEY_W-1:0] i_key_value,
    input  logic [slist_pkg::POS_W-1:0]        i_position,
    // memory
    output logic                               o_we,
    output logic [AW-1:0]                      o_waddr,
    output logic signed [slist_pkg::KEY_W-1:0] o_wdata,
    output logic [AW-1:0]                      o_raddr,
    input  logic signed [slist_pkg::KEY_W-1:0] i_rdata,
    // result offer and grant from the output register
    output slist_pkg::t_emit                   o_emit,
    input  logic                               i_emit_gnt
);
    import slist_pkg::*;

    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_count, n_count;
    t_status                 r_res_status, n_res_status;
    logic signed [KEY_W-1:0] r_res_value, n_res_value;

    t_cmd          in_cmd;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          pos_bad;
    logic          key_ge;
    logic          hit;
    logic          more1;
    logic          more2;
    logic          list_last;
    logic [CW-1:0] idx1;
    logic [CW-1:0] idx2;

    // shared decode and the one comparator path
    assign in_cmd    = t_cmd'(i_cmd);
    assign accept    = i_valid && (r_state == S_IDLE);
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign pos_bad   = (i_position == '0) || (PW'(i_position) > PW'(r_count));
    assign key_ge    = !(i_rdata < r_key);
    assign hit       = (r_cmd == CMD_DEL_POS) || (i_rdata == r_key);
    assign idx1      = CW'(r_idx) + CW'(1);
    assign idx2      = CW'(r_idx) + CW'(2);
    assign more1     = (idx1 < r_count);
    assign more2     = (idx2 < r_count);
    assign list_last = (idx1 == r_count);
    assign o_stall   = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (is_full)       n_state = S_RESULT;
                            else if (is_empty) n_state = S_INS_PUT;
                            else               n_state = S_INS_RD;
                        end
                        CMD_DEL_POS: n_state = pos_bad ? S_RESULT : S_FETCH;
                        CMD_DEL_VAL: n_state = is_empty ? S_RESULT : S_FETCH;
                        CMD_LIST:    n_state = is_empty ? S_RESULT : S_FETCH;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (!key_ge)                n_state = S_RESULT;
                else if (r_idx == AW'(1))   n_state = S_INS_PUT;
            end
            S_INS_PUT: n_state = S_RESULT;
            S_FETCH:   n_state = (r_cmd == CMD_LIST) ? S_LIST : S_MATCH;
            S_MATCH: begin
                if (hit)         n_state = more1 ? S_SHIFT : S_RESULT;
                else if (!more1) n_state = S_RESULT;
            end
            S_SHIFT: begin
                if (!more2) n_state = S_RESULT;
            end
            S_LIST: begin
                if (i_emit_gnt && list_last) n_state = S_IDLE;
            end
            S_RESULT: begin
                if (i_emit_gnt) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control, memory requests and result offer
    always_comb begin
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        o_we         = 1'b0;
        o_waddr      = r_idx;
        o_wdata      = r_key;
        o_raddr      = r_idx;
        o_emit       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = ST_OK;
                    n_res_value  = '0;
                    n_idx        = '0;
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (is_full)        n_res_status = ST_FULL;
                            else if (!is_empty) n_idx = AW'(r_count);
                        end
                        CMD_DEL_POS: begin
                            if (pos_bad) n_res_status = ST_NOT_FOUND;
                            else         n_idx = AW'(i_position - POS_W'(1));
                        end
                        CMD_DEL_VAL: begin
                            if (is_empty) n_res_status = ST_NOT_FOUND;
                        end
                        CMD_LIST: begin
                            if (is_empty) n_res_status = ST_EMPTY;
                        end
                        default: n_res_status = ST_OK;
                    endcase
                end
            end
            S_INS_RD: begin
                o_raddr = r_idx - AW'(1);
            end
            S_INS_CMP: begin
                // larger-or-equal entry moves up one slot, else the key lands here
                o_we    = 1'b1;
                o_waddr = r_idx;
                if (key_ge) begin
                    o_wdata = i_rdata;
                    n_idx   = r_idx - AW'(1);
                    o_raddr = r_idx - AW'(2);
                end else begin
                    o_wdata     = r_key;
                    n_count     = r_count + CW'(1);
                    n_res_value = r_key;
                end
            end
            S_INS_PUT: begin
                o_we        = 1'b1;
                o_waddr     = r_idx;
                o_wdata     = r_key;
                n_count     = r_count + CW'(1);
                n_res_value = r_key;
            end
            S_FETCH: begin
                o_raddr = r_idx;
            end
            S_MATCH: begin
                if (hit) begin
                    n_res_value = i_rdata;
                    o_raddr     = AW'(idx1);
                    if (!more1) n_count = r_count - CW'(1);
                end else if (more1) begin
                    n_idx   = AW'(idx1);
                    o_raddr = AW'(idx1);
                end else begin
                    n_res_status = ST_NOT_FOUND;
                end
            end
            S_SHIFT: begin
                // close the gap: entry above moves down one slot
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = AW'(idx1);
                o_raddr = AW'(idx2);
                if (!more2) n_count = r_count - CW'(1);
            end
            S_LIST: begin
                o_emit.vld    = 1'b1;
                o_emit.status = ST_OK;
                o_emit.value  = i_rdata;
                o_emit.count  = CNT_OUT_W'(r_count);
                o_emit.last   = list_last;
                if (i_emit_gnt) begin
                    n_idx   = AW'(idx1);
                    o_raddr = AW'(idx1);
                end
            end
            S_RESULT: begin
                o_emit.vld    = 1'b1;
                o_emit.status = r_res_status;
                o_emit.value  = r_res_value;
                o_emit.count  = CNT_OUT_W'(r_count);
                o_emit.last   = 1'b1;
            end
            default: n_idx = r_idx;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // command and working registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (accept) begin
            r_cmd <= in_cmd;
            r_key <= i_key_value;
        end
    end

endmodule

@@ hdl/sorted_list_engine.sv @@
// Sorted list engine: holds up to DEPTH signed 32-bit keys in ascending order.
// Command channel (i_valid / o_stall) carries i_cmd, i_key_value, i_position;
// a transaction is taken when i_valid is high and o_stall is low. Commands are
// insert (ahead of equal keys), delete at 1-based position, delete first
// matching value, and list all. Result channel (o_valid / i_stall) carries
// o_status, o_entry_value, o_entry_count, o_last; o_last marks the final result.
// One command is in work at a time; o_stall is high until its results are all
// handed to the output register. An insert moves up each key greater or equal
// to the new key; a delete at a position moves down each key above the target;
// a delete by value scans up to the first match and moves down the keys above
// it, or scans every key when none matches; a list emits every key in order.
// Full, bad position and empty list refusals go straight to their result.
// All walks go through the single read and write port of the key memory, one
// entry per cycle, and a list walk holds while its result is not taken. The
// output register lets the engine take the next command while a result still
// waits; a stalled result holds until taken, and the sequencer waits behind it.
// Synchronous reset empties the list and drops any result in flight; the key
// memory itself is not cleared.
module sorted_list_engine #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_cmd,
    input  logic signed [slist_pkg::KEY_W-1:0]     i_key_value,
    input  logic [slist_pkg::POS_W-1:0]            i_position,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_status,
    output logic signed [slist_pkg::KEY_W-1:0]     o_entry_value,
    output logic [slist_pkg::CNT_OUT_W-1:0]        o_entry_count,
    output logic                                   o_last
);
    import slist_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic signed [KEY_W-1:0] mem_rdata;
    t_emit                   emit;
    logic                    emit_gnt;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic signed [KEY_W-1:0] r_out_value;
    logic [CNT_OUT_W-1:0]    r_out_count;
    logic                    r_out_last;

    slist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    slist_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_key_value (i_key_value),
        .i_position  (i_position),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_emit      (emit),
        .i_emit_gnt  (emit_gnt)
    );

    // output register takes a new result when empty or being drained
    assign emit_gnt = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_gnt) begin
            r_out_valid <= emit.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_gnt && emit.vld) begin
            r_out_status <= emit.status;
            r_out_value  <= emit.value;
            r_out_count  <= emit.count;
            r_out_last   <= emit.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

endmodule

@@ hdl/slist_chk.sv @@
// Port-level checks for the sorted list engine, attached by bind.
// Depends on slist_pkg and sorted_list_engine.
module slist_chk #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [1:0]                         o_status,
    input logic signed [slist_pkg::KEY_W-1:0] o_entry_value,
    input logic [slist_pkg::CNT_OUT_W-1:0]    o_entry_count,
    input logic                               o_last
);
    import slist_pkg::*;

    // a held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_value) && $stable(o_last))
        else $error("stalled result changed");

    // an accepted command leaves the engine busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("engine took a command without going busy");

    // refusals carry a zero key and close the command
    a_refusal_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_NOT_FOUND ||
                    o_status == ST_EMPTY)
        |-> o_last && (o_entry_value == '0))
        else $error("refusal result malformed");

    // a full refusal reports a full list, an empty listing reports no keys
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_EMPTY)
        |-> (o_status == ST_FULL) ? (o_entry_count == CNT_OUT_W'(DEPTH))
                                  : (o_entry_count == '0))
        else $error("key count disagrees with status");

endmodule

bind sorted_list_engine slist_chk #(
    .DEPTH (DEPTH)
) u_slist_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_entry_value (o_entry_value),
    .o_entry_count (o_entry_count),
    .o_last        (o_last)
);

@@ verif/testbench.sv @@
// Self-checking testbench for sorted_list_engine: directed and random commands,
// results checked against a shadow copy of the sorted key list.
// Depends on hdl/slist_pkg.sv and hdl/sorted_list_engine.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slist_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int MAX_GAP       = 17;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 34;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 600000;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [POS_W-1:0]        t_pos;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_status              status;
        t_key                 value;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_cmd;
    t_key                 i_key_value;
    t_pos                 i_position;
    logic                 o_valid;
    logic                 i_stall;
    logic [1:0]           o_status;
    t_key                 o_entry_value;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic                 o_last;

    // Shadow of the list contents and the results still owed by the engine
    t_key    shadow_keys [DEPTH];
    int      shadow_count;
    t_result awaited_results[$];

    int error_count;
    int cycle_count;
    bit src_gaps;
    bit sink_gaps;

    sorted_list_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_key_value   (i_key_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding",
                     $time, awaited_results.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Shadow list
    // ---------------------------------------------------------------
    task automatic push_result(input t_status status, input t_key value, input bit last);
        t_result r;
        r.status = status;
        r.value  = value;
        r.count  = shadow_count[CNT_OUT_W-1:0];
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    task automatic remove_entry(input int idx);
        int i;
        for (i = idx; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
    endtask

    // Applies one accepted command to the shadow list and queues its results
    task automatic predict_command(input t_cmd cmd, input t_key key, input t_pos pos);
        int   slot;
        int   idx;
        bit   hit;
        t_key removed;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    // new key goes ahead of any equal keys
                    slot = 0;
                    while (slot < shadow_count && shadow_keys[slot] < key)
                        slot++;
                    for (idx = shadow_count; idx > slot; idx--)
                        shadow_keys[idx] = shadow_keys[idx - 1];
                    shadow_keys[slot] = key;
                    shadow_count++;
                    push_result(ST_OK, key, 1'b1);
                end
            end
            CMD_DEL_POS: begin
                if (pos == 0 || int'(pos) > shadow_count) begin
                    push_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    removed = shadow_keys[pos - 1];
                    remove_entry(int'(pos) - 1);
                    push_result(ST_OK, removed, 1'b1);
                end
            end
            CMD_DEL_VAL: begin
                hit = 1'b0;
                for (idx = 0; idx < shadow_count && !hit; idx++) begin
                    if (shadow_keys[idx] == key) begin
                        hit = 1'b1;
                        remove_entry(idx);
                    end
                end
                if (hit)
                    push_result(ST_OK, key, 1'b1);
                else
                    push_result(ST_NOT_FOUND, '0, 1'b1);
            end
            default: begin
                if (shadow_count == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (idx = 0; idx < shadow_count; idx++)
                        push_result(ST_OK, shadow_keys[idx], idx + 1 == shadow_count);
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Command side: one transaction per call
    // ---------------------------------------------------------------
    task automatic send_command(input t_cmd cmd, input t_key key, input t_pos pos);
        int gap;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_key_value <= key;
        i_position  <= pos;
        do @(posedge i_clk); while (o_stall);
        predict_command(cmd, key, pos);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall before each result
    // ---------------------------------------------------------------
    initial begin : result_sink
        int gap;
        i_stall <= 1'b0;
        forever begin
            gap = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // Compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d value %0d",
                         $time, o_status, o_entry_value);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_entry_value !== want.value) begin
                    $display("%0t: entry_value mismatch: expected %0d actual %0d",
                             $time, want.value, o_entry_value);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count mismatch: expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0d actual %0d",
                             $time, want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Small values for duplicates and hits, extremes, and full-range keys
    function automatic t_key pick_key();
        t_key k;
        case ($urandom_range(0, 3))
            0: k = t_key'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 5))
                    0: k = KEY_MAX;
                    1: k = KEY_MIN;
                    2: k = KEY_MAX - 1;
                    3: k = KEY_MIN + 1;
                    4: k = '0;
                    default: k = '1;
                endcase
            end
            default: k = t_key'($urandom);
        endcase
        return k;
    endfunction

    function automatic t_key held_or_random_key();
        if (shadow_count > 0 && $urandom_range(0, 9) < 7)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        return pick_key();
    endfunction

    function automatic t_pos pick_position();
        if (shadow_count > 0 && $urandom_range(0, 9) < 8)
            return t_pos'($urandom_range(1, shadow_count));
        return t_pos'($urandom_range(0, 31));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Commands on a list that has never held a key
    task automatic test_empty_list();
        send_command(CMD_LIST,    t_key'($urandom), t_pos'($urandom));
        send_command(CMD_DEL_POS, t_key'($urandom), 5'd1);
        send_command(CMD_DEL_POS, t_key'($urandom), 5'd0);
        send_command(CMD_DEL_VAL, '0,               t_pos'($urandom));
    endtask

    // Extreme keys, duplicates, bad positions and missing values
    task automatic test_extremes();
        send_command(CMD_INSERT,  KEY_MAX, 5'd0);
        send_command(CMD_INSERT,  KEY_MIN, 5'd31);
        send_command(CMD_INSERT,  '0,      5'd16);
        send_command(CMD_INSERT,  '1,      5'd1);
        send_command(CMD_INSERT,  '0,      5'd0);
        send_command(CMD_INSERT,  KEY_MIN, 5'd0);
        send_command(CMD_LIST,    KEY_MAX, 5'd31);
        send_command(CMD_DEL_POS, '0,      5'd0);
        send_command(CMD_DEL_POS, '0,      5'd31);
        send_command(CMD_DEL_POS, '0,      5'd7);
        send_command(CMD_DEL_POS, '0,      5'd3);
        send_command(CMD_DEL_VAL, '1,      5'd31);
        send_command(CMD_DEL_VAL, 32'sd12345, 5'd0);
        send_command(CMD_DEL_VAL, KEY_MIN, 5'd0);
        send_command(CMD_LIST,    '0,      5'd0);
        send_command(CMD_DEL_POS, '0,      5'd1);
        send_command(CMD_DEL_POS, '0,      t_pos'(shadow_count));
    endtask

    // Fill to capacity, push past it, then work at the top end
    task automatic test_full_list();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        while (shadow_count < DEPTH)
            send_command(CMD_INSERT, pick_key(), t_pos'($urandom));
        repeat (3) send_command(CMD_INSERT, pick_key(), t_pos'($urandom));
        send_command(CMD_LIST,    t_key'($urandom), t_pos'($urandom));
        send_command(CMD_DEL_POS, t_key'($urandom), t_pos'(DEPTH));
        send_command(CMD_INSERT,  KEY_MAX, t_pos'($urandom));
        send_command(CMD_INSERT,  KEY_MIN, t_pos'($urandom));
        send_command(CMD_DEL_VAL, held_or_random_key(), t_pos'($urandom));
        send_command(CMD_LIST,    t_key'($urandom), t_pos'($urandom));
    endtask

    // Phases that grow, shrink or hold the list, with varied idling
    task automatic test_random_traffic();
        int phase;
        int n;
        int roll;
        int ins_lim;
        int dpos_lim;
        int dval_lim;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            src_gaps  = (phase % 4 == 0) || (phase % 4 == 2);
            sink_gaps = (phase % 4 == 0) || (phase % 4 == 3);
            case (phase % 3)
                0: begin ins_lim = 65; dpos_lim = 75; dval_lim = 85; end
                1: begin ins_lim = 15; dpos_lim = 50; dval_lim = 85; end
                default: begin ins_lim = 40; dpos_lim = 60; dval_lim = 80; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_lim)
                    send_command(CMD_INSERT, pick_key(), t_pos'($urandom));
                else if (roll < dpos_lim)
                    send_command(CMD_DEL_POS, t_key'($urandom), pick_position());
                else if (roll < dval_lim)
                    send_command(CMD_DEL_VAL, held_or_random_key(), t_pos'($urandom));
                else
                    send_command(CMD_LIST, t_key'($urandom), t_pos'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        error_count  = 0;
        cycle_count  = 0;
        shadow_count = 0;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_INSERT;
        i_key_value <= '0;
        i_position  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_extremes();
        test_full_list();
        test_random_traffic();

        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
